### hdl/dspm_pkg.sv
// ----------------------------------------------------------------------------
// dspm_pkg
// Shared widths, codes and types of the dose sample position merger.
// ----------------------------------------------------------------------------
package dspm_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int IDX_W          = $clog2(QUEUE_DEPTH);
  localparam int FILL_W         = IDX_W + 1;
  localparam int REPEAT_DIVISOR = 5;
  localparam int FIELD_W        = 24;
  localparam int NFIELDS        = 8;
  localparam int NPOS           = 6;
  localparam int DATA_W         = FIELD_W * NFIELDS;
  localparam int SUM_W          = FIELD_W + IDX_W + 1;
  localparam int MAG_W          = SUM_W - 1;
  localparam int DIVCNT_W       = $clog2(MAG_W + 1);
  localparam int DIFF_W         = FIELD_W + 1;
  localparam int SQ_W           = 2 * FIELD_W + 1;
  localparam int DIST_W         = SQ_W + 2;
  localparam int CUT_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_DOSE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd3;
  localparam logic [CUT_W-1:0]     CUTOFF_RESET  = 32'd2500;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROUTE, ST_APPEND,
    ST_CHK_RD, ST_CHK_DF, ST_CHK_SQ, ST_CHK_CMP,
    ST_SC_RD, ST_SC_DF, ST_SC_SQ, ST_SC_CMP,
    ST_DECIDE, ST_DIV, ST_EMIT_MEAN, ST_EMIT_SAMPLE
  } state_t;

  typedef struct packed {
    logic capture;
    logic append;
    logic clear;
    logic rd_last;
    logic scan_inc;
    logic max_upd;
    logic div_start;
    logic div_step;
    logic load_mean;
    logic load_sample;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic              fill_zero;
    logic              moved;
    logic              scan_done;
    logic              flush;
    logic              div_done;
    logic              last_rep;
    logic              out_free;
    logic [FILL_W-1:0] fill;
  } sts_t;

endpackage

### hdl/dspm_datapath.sv
// ----------------------------------------------------------------------------
// dspm_datapath
// Sample register, position queue, running sums, distance unit, divider and
// output register of the merger.
// ----------------------------------------------------------------------------
module dspm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dspm_pkg::cmd_t                cmd,
  input  logic [dspm_pkg::DATA_W-1:0]   in_data,
  input  logic [dspm_pkg::FIELD_W-1:0]  bg_count,
  input  logic [dspm_pkg::FIELD_W-1:0]  bg_dose,
  input  logic [dspm_pkg::CUT_W-1:0]    cutoff,
  output dspm_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dspm_pkg::DATA_W-1:0]   out_data,
  output logic                          out_mean,
  output logic                          out_last
);
  import dspm_pkg::*;

  logic [FIELD_W-1:0]      samp [NFIELDS];
  logic [3*FIELD_W-1:0]    qmem [QUEUE_DEPTH];
  logic [3*FIELD_W-1:0]    rd_data;
  logic [IDX_W-1:0]        rd_addr;
  logic [FILL_W-1:0]       fill;
  logic [FILL_W-1:0]       fill_m1;
  logic [IDX_W-1:0]        scan_idx;
  logic signed [DIFF_W-1:0] diff [3];
  logic [SQ_W-1:0]         sq [3];
  logic signed [2*DIFF_W-1:0] prod [3];
  logic [DIST_W-1:0]       dsq;
  logic [DIST_W-1:0]       maxd;
  logic [DIST_W-1:0]       cut_ext;
  logic signed [SUM_W-1:0] sum [NFIELDS];
  logic signed [SUM_W-1:0] addend [NFIELDS];
  logic [MAG_W-1:0]        quo [NFIELDS];
  logic [IDX_W:0]          rem [NFIELDS];
  logic                    neg [NFIELDS];
  logic [DIVCNT_W-1:0]     div_cnt;
  logic [FILL_W-1:0]       left;
  logic [FIELD_W-1:0]      mean [NFIELDS];
  logic [FIELD_W-1:0]      adj_count;
  logic [FIELD_W-1:0]      adj_dose;
  logic [FIELD_W-1:0]      raw_count;
  logic [FIELD_W-1:0]      raw_dose;

  assign raw_count = in_data[6*FIELD_W +: FIELD_W];
  assign raw_dose  = in_data[7*FIELD_W +: FIELD_W];
  assign adj_count = (raw_count > bg_count) ? raw_count - bg_count : '0;
  assign adj_dose  = (raw_dose > bg_dose) ? raw_dose - bg_dose : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int f = 0; f < NPOS; f++) begin
        samp[f] <= in_data[f*FIELD_W +: FIELD_W];
      end
      samp[6] <= adj_count;
      samp[7] <= adj_dose;
    end
  end

  // Queue of sensor positions; rates and base positions live only in the sums.
  assign fill_m1 = fill - FILL_W'(1);
  assign rd_addr = cmd.rd_last ? fill_m1[IDX_W-1:0] : scan_idx;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      qmem[fill[IDX_W-1:0]] <= {samp[2], samp[1], samp[0]};
    end
    rd_data <= qmem[rd_addr];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = diff[k] * diff[k];
    end
    dsq = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      diff[k] <= DIFF_W'($signed(samp[k])) - DIFF_W'($signed(rd_data[k*FIELD_W +: FIELD_W]));
      sq[k]   <= prod[k][SQ_W-1:0];
    end
  end

  assign cut_ext = DIST_W'(cutoff);

  always_comb begin
    for (int f = 0; f < NFIELDS; f++) begin
      if (f < NPOS) begin
        addend[f] = SUM_W'($signed(samp[f]));
      end else begin
        addend[f] = $signed(SUM_W'(samp[f]));
      end
      mean[f] = neg[f] ? FIELD_W'(-quo[f]) : quo[f][FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      maxd     <= '0;
      scan_idx <= '0;
      div_cnt  <= '0;
      left     <= '0;
      for (int f = 0; f < NFIELDS; f++) begin
        sum[f] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        fill <= '0;
        maxd <= '0;
        for (int f = 0; f < NFIELDS; f++) begin
          sum[f] <= '0;
        end
      end else if (cmd.append) begin
        fill <= fill + FILL_W'(1);
        for (int f = 0; f < NFIELDS; f++) begin
          sum[f] <= sum[f] + addend[f];
        end
      end
      if (cmd.max_upd && dsq > maxd) begin
        maxd <= dsq;
      end
      if (cmd.append) begin
        scan_idx <= '0;
      end else if (cmd.scan_inc) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.div_start) begin
        div_cnt <= DIVCNT_W'(MAG_W);
        left    <= fill;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - DIVCNT_W'(1);
      end
      if (cmd.load_mean) begin
        left <= sts.last_rep ? '0 : left - FILL_W'(REPEAT_DIVISOR);
      end
    end
  end

  // Restoring divider, one quotient bit per cycle in all eight lanes.
  always_ff @(posedge clk) begin
    for (int f = 0; f < NFIELDS; f++) begin
      logic [IDX_W+1:0] rsh;
      rsh = {rem[f], quo[f][MAG_W-1]};
      if (cmd.div_start) begin
        neg[f] <= sum[f][SUM_W-1];
        quo[f] <= sum[f][SUM_W-1] ? MAG_W'(-sum[f]) : MAG_W'(sum[f]);
        rem[f] <= '0;
      end else if (cmd.div_step) begin
        if (rsh >= (IDX_W+2)'(fill)) begin
          rem[f] <= (IDX_W+1)'(rsh - (IDX_W+2)'(fill));
          quo[f] <= {quo[f][MAG_W-2:0], 1'b1};
        end else begin
          rem[f] <= rsh[IDX_W:0];
          quo[f] <= {quo[f][MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_mean || cmd.load_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mean || cmd.load_sample) begin
      for (int f = 0; f < NFIELDS; f++) begin
        out_data[f*FIELD_W +: FIELD_W] <= cmd.load_mean ? mean[f] : samp[f];
      end
      out_mean <= cmd.load_mean;
      out_last <= cmd.last;
    end
  end

  always_comb begin
    sts.fill_zero = (fill == '0);
    sts.moved     = (dsq > cut_ext);
    sts.scan_done = ((FILL_W'(scan_idx) + FILL_W'(2)) == fill);
    sts.flush     = (maxd > cut_ext) || (fill == FILL_W'(QUEUE_DEPTH));
    sts.div_done  = (div_cnt == '0);
    sts.last_rep  = (left <= FILL_W'(REPEAT_DIVISOR));
    sts.out_free  = !out_valid || out_ready;
    sts.fill      = fill;
  end

endmodule

### hdl/dspm_ctrl.sv
// ----------------------------------------------------------------------------
// dspm_ctrl
// Sequencer of the merger: routes each sample, walks the queue and drives
// the emission of mean words and single sample words.
// ----------------------------------------------------------------------------
module dspm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           bypass,
  input  dspm_pkg::sts_t sts,
  output dspm_pkg::cmd_t cmd
);
  import dspm_pkg::*;

  state_t state;
  state_t state_next;
  logic   moved;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      moved <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        moved <= 1'b0;
      end else if (state == ST_CHK_CMP && sts.moved) begin
        moved <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_ROUTE;
      ST_ROUTE: begin
        if (bypass) begin
          state_next = ST_EMIT_SAMPLE;
        end else if (sts.fill_zero) begin
          state_next = ST_APPEND;
        end else begin
          state_next = ST_CHK_RD;
        end
      end
      ST_APPEND:  state_next = sts.fill_zero ? ST_IDLE : ST_SC_RD;
      ST_CHK_RD:  state_next = ST_CHK_DF;
      ST_CHK_DF:  state_next = ST_CHK_SQ;
      ST_CHK_SQ:  state_next = ST_CHK_CMP;
      ST_CHK_CMP: state_next = sts.moved ? ST_DIV : ST_APPEND;
      ST_SC_RD:   state_next = ST_SC_DF;
      ST_SC_DF:   state_next = ST_SC_SQ;
      ST_SC_SQ:   state_next = ST_SC_CMP;
      ST_SC_CMP:  state_next = sts.scan_done ? ST_DECIDE : ST_SC_RD;
      ST_DECIDE:  state_next = sts.flush ? ST_DIV : ST_IDLE;
      ST_DIV:     if (sts.div_done) state_next = ST_EMIT_MEAN;
      ST_EMIT_MEAN: begin
        if (sts.out_free && sts.last_rep) begin
          state_next = moved ? ST_EMIT_SAMPLE : ST_IDLE;
        end
      end
      ST_EMIT_SAMPLE: if (sts.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_APPEND:  cmd.append = 1'b1;
      ST_CHK_RD:  cmd.rd_last = 1'b1;
      ST_CHK_CMP: cmd.div_start = sts.moved;
      ST_SC_CMP: begin
        cmd.max_upd  = 1'b1;
        cmd.scan_inc = !sts.scan_done;
      end
      ST_DECIDE:  cmd.div_start = sts.flush;
      ST_DIV:     cmd.div_step = !sts.div_done;
      ST_EMIT_MEAN: begin
        if (sts.out_free) begin
          cmd.load_mean = 1'b1;
          cmd.last      = sts.last_rep && !moved;
          cmd.clear     = sts.last_rep && !moved;
        end
      end
      ST_EMIT_SAMPLE: begin
        if (sts.out_free) begin
          cmd.load_sample = 1'b1;
          cmd.last        = 1'b1;
          cmd.clear       = moved;
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/dose_sample_position_merger_unit.sv
// ----------------------------------------------------------------------------
// dose_sample_position_merger_unit
// Merges position-tagged radiation samples taken at nearly the same place.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Carries
// s_*       in         one sample word: positions and raw rates
// m_*       out        one result word: position and rates, mean flag, last
// cfg_*     in         register writes: bypass, backgrounds, distance cutoff
//
// An accepted word first passes through the routing state. In bypass mode
// the adjusted sample then goes to the emit state, which loads it into the
// output register, and the sequencer returns to idle for the next word.
// Otherwise the distance test against the last queued position runs through
// the read, difference, square and compare states and, if it stays, the
// append; the walk over the n-1 older queue entries runs through the same
// states per entry in the shared squaring unit. A flush runs the serial
// divider over 28 quotient bits, then emits the mean words, and the new
// sample after them when it moved away. The next sample is accepted only
// when the sequencer is back in idle, while the last result word may still
// wait in the output register. Reset is synchronous and clears the queue
// count, the sums and all control state; no clearing pass is needed. A
// stalled output holds the sequencer in its emit state.
//
module dose_sample_position_merger_unit (
  input  logic                                clk,
  input  logic                                rst,
  // sensor_x, sensor_y, sensor_z, base_x, base_y, base_z, count_rate,
  // dose intensity, 24 bits each, from the lowest bit up
  input  logic [dspm_pkg::DATA_W-1:0]         s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // out_sensor_x, out_sensor_y, out_sensor_z, out_base_x, out_base_y,
  // out_base_z, out_count_rate, output dose intensity, 24 bits each,
  // lowest bit up
  output logic [dspm_pkg::DATA_W-1:0]         m_tdata,
  // is_mean
  output logic [0:0]                          m_tuser,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [dspm_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [dspm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dspm_pkg::*;

  logic               bypass_merge;
  logic [FIELD_W-1:0] background_count_rate;
  logic [FIELD_W-1:0] background_dose;
  logic [CUT_W-1:0]   distance_cutoff_squared;
  cmd_t               cmd;
  sts_t               sts;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_merge            <= 1'b0;
      background_count_rate   <= '0;
      background_dose         <= '0;
      distance_cutoff_squared <= CUTOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BYPASS:   bypass_merge            <= cfg_data[0];
        CFG_BG_COUNT: background_count_rate   <= cfg_data[FIELD_W-1:0];
        CFG_BG_DOSE:  background_dose         <= cfg_data[FIELD_W-1:0];
        CFG_CUTOFF:   distance_cutoff_squared <= cfg_data[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  dspm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .bypass   (bypass_merge),
    .sts      (sts),
    .cmd      (cmd)
  );

  dspm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_tdata),
    .bg_count  (background_count_rate),
    .bg_dose   (background_dose),
    .cutoff    (distance_cutoff_squared),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_mean  (m_tuser[0]),
    .out_last  (m_tlast)
  );

  // The queue never holds more entries than its depth.
  assert property (@(posedge clk) disable iff (rst)
    sts.fill <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  // A single sample word always closes its run.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("single sample word without last");

  // Only one sample is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while busy");

endmodule

### dv/tb_dose_sample_position_merger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dose_sample_position_merger_unit
// Drives position-tagged radiation samples into the merger and compares every
// result word with a local software copy of the merge rules.
// ----------------------------------------------------------------------------
module tb_dose_sample_position_merger_unit;
  import dspm_pkg::*;

  // One sample or one result: six positions and two rates.
  typedef struct {
    logic signed [23:0] pos [6];
    logic [23:0]        rate [2];
  } sample_t;

  typedef struct {
    sample_t s;
    logic    mean;
    logic    last;
  } merged_word_t;

  logic                  clk;
  logic                  rst;
  logic [DATA_W-1:0]     s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [DATA_W-1:0]     m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  dose_sample_position_merger_unit DUT (.*);

  // Shadow copy of the configuration and of the merge queue.
  logic        sh_bypass;
  logic [23:0] sh_bg_count;
  logic [23:0] sh_bg_dose;
  logic [31:0] sh_cutoff;
  sample_t     merge_queue [QUEUE_DEPTH];
  int          merge_fill;

  merged_word_t expected_words [$];
  int  mismatches;
  int  words_checked;
  int  mean_words;
  int  samples_sent;
  int  cycle_count;
  int  burst_left;
  bit  stall_enable;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run cannot legitimately take this long; a hang ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The receiver stalls on its own pattern: runs of ready and of not ready.
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      stall_phase <= 0;
    end else if (stall_phase == 0) begin
      if (!stall_enable || $urandom_range(0, 2) != 0) begin
        m_tready    <= 1'b1;
        stall_phase <= $urandom_range(1, 8);
      end else begin
        m_tready    <= 1'b0;
        stall_phase <= $urandom_range(1, 12);
      end
    end else begin
      stall_phase <= stall_phase - 1;
    end
  end

  // Squared sensor distance between two samples; 25-bit differences, so a
  // 64-bit unsigned sum is exact.
  function automatic logic [63:0] sensor_dist2(sample_t a, sample_t b);
    logic signed [63:0] d;
    logic [63:0]        acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      d   = 64'(a.pos[k]) - 64'(b.pos[k]);
      acc = acc + 64'(d * d);
    end
    return acc;
  endfunction

  // Appends one expected word at the tail of the queue.
  task automatic add_expected(sample_t smp, logic is_mean, logic is_last);
    merged_word_t w;
    w.s    = smp;
    w.mean = is_mean;
    w.last = is_last;
    expected_words.insert(expected_words.size(), w);
  endtask

  // Appends the mean of the queue, repeated ceil(n/5) times.
  task automatic push_queue_mean();
    sample_t            avg;
    logic signed [63:0] acc;
    int                 reps;
    if (merge_fill == 0) return;
    for (int f = 0; f < 8; f++) begin
      acc = '0;
      for (int i = 0; i < merge_fill; i++)
        acc += (f < 6) ? 64'(merge_queue[i].pos[f])
                       : $signed({40'd0, merge_queue[i].rate[f-6]});
      acc = acc / merge_fill;  // SystemVerilog division truncates toward zero
      if (f < 6) avg.pos[f] = acc[23:0];
      else avg.rate[f-6] = acc[23:0];
    end
    reps = (merge_fill + REPEAT_DIVISOR - 1) / REPEAT_DIVISOR;
    for (int r = 0; r < reps; r++) add_expected(avg, 1'b1, 1'b0);
  endtask

  // Works out the words that one accepted sample causes.
  task automatic predict_merge(sample_t raw);
    sample_t     adj;
    logic [63:0] widest;
    int          first_new;
    first_new = expected_words.size();
    adj = raw;
    adj.rate[0] = raw.rate[0] > sh_bg_count ? raw.rate[0] - sh_bg_count : 24'd0;
    adj.rate[1] = raw.rate[1] > sh_bg_dose  ? raw.rate[1] - sh_bg_dose  : 24'd0;
    if (sh_bypass) begin
      add_expected(adj, 1'b0, 1'b1);
      return;
    end
    if (merge_fill == 0) begin
      merge_queue[0] = adj;
      merge_fill = 1;
      return;
    end
    if (sensor_dist2(adj, merge_queue[merge_fill-1]) > 64'(sh_cutoff)) begin
      // Moved away: flush the mean, then the new sample itself.
      push_queue_mean();
      add_expected(adj, 1'b0, 1'b0);
      merge_fill = 0;
    end else begin
      merge_queue[merge_fill] = adj;
      merge_fill++;
      widest = '0;
      for (int i = 0; i < merge_fill - 1; i++)
        for (int j = i + 1; j < merge_fill; j++)
          if (sensor_dist2(merge_queue[i], merge_queue[j]) > widest)
            widest = sensor_dist2(merge_queue[i], merge_queue[j]);
      if (widest > 64'(sh_cutoff) || merge_fill >= QUEUE_DEPTH) begin
        push_queue_mean();
        merge_fill = 0;
      end
    end
    if (expected_words.size() > first_new)
      expected_words[expected_words.size()-1].last = 1'b1;
  endtask

  // Checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    merged_word_t exp_w;
    logic [DATA_W-1:0] exp_data;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word %h at cycle %0d", m_tdata, cycle_count);
      end else begin
        exp_w = expected_words.pop_front();
        for (int f = 0; f < 6; f++) exp_data[f*24 +: 24] = exp_w.s.pos[f];
        exp_data[144 +: 24] = exp_w.s.rate[0];
        exp_data[168 +: 24] = exp_w.s.rate[1];
        words_checked++;
        if (exp_w.mean) mean_words++;
        if (m_tdata !== exp_data || m_tuser[0] !== exp_w.mean ||
            m_tlast !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch word %0d: expected %h mean %b last %b, got %h mean %b last %b",
                     words_checked, exp_data, exp_w.mean, exp_w.last,
                     m_tdata, m_tuser[0], m_tlast);
        end
      end
    end
  end

  // Sends one sample word: bursts of closely spaced words with random gaps.
  task automatic send_sample(sample_t smp);
    logic [DATA_W-1:0] packed_data;
    for (int f = 0; f < 6; f++) packed_data[f*24 +: 24] = smp.pos[f];
    packed_data[144 +: 24] = smp.rate[0];
    packed_data[168 +: 24] = smp.rate[1];
    @(posedge clk);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    s_tdata  <= packed_data;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
    predict_merge(smp);
    samples_sent++;
  endtask

  // Waits until every expected word has arrived, then lets the sequencer
  // finish any work that produces no word.
  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_BYPASS:   sh_bypass   = val[0];
      CFG_BG_COUNT: sh_bg_count = val[23:0];
      CFG_BG_DOSE:  sh_bg_dose  = val[23:0];
      default:      sh_cutoff   = val;
    endcase
    @(posedge clk);
  endtask

  // A sample near a given point; spread 0 gives the exact point.
  function automatic sample_t near_point(sample_t c, int spread);
    sample_t r;
    r = c;
    for (int k = 0; k < 3; k++)
      r.pos[k] = 24'(c.pos[k] + $signed($urandom_range(0, 2*spread)) - spread);
    for (int k = 3; k < 6; k++) r.pos[k] = 24'($urandom);
    r.rate[0] = 24'($urandom);
    r.rate[1] = 24'($urandom);
    return r;
  endfunction

  function automatic sample_t random_sample();
    sample_t r;
    for (int k = 0; k < 6; k++) r.pos[k] = 24'($urandom);
    r.rate[0] = 24'($urandom);
    r.rate[1] = 24'($urandom);
    return r;
  endfunction

  // Extremes of every field, in bypass with and without backgrounds.
  task automatic test_bypass_extremes();
    sample_t s;
    write_reg(CFG_BYPASS, 32'd1);
    for (int v = 0; v < 4; v++) begin
      for (int k = 0; k < 6; k++)
        s.pos[k] = (v == 0) ? 24'h800000 : (v == 1) ? 24'h7FFFFF :
                   (v == 2) ? 24'h0 : 24'hFFFFFF;
      s.rate[0] = (v[0]) ? 24'hFFFFFF : 24'd0;
      s.rate[1] = (v[0]) ? 24'd0 : 24'hFFFFFF;
      send_sample(s);
    end
    drain();
    write_reg(CFG_BG_COUNT, 32'd1000);
    write_reg(CFG_BG_DOSE, 32'hFFFFFF);
    s = random_sample(); s.rate[0] = 24'd1000; send_sample(s);  // equal: clamps
    s.rate[0] = 24'd1001; s.rate[1] = 24'hFFFFFF; send_sample(s);
    drain();
  endtask

  // Directed merge cases: empty queue, moved away, spread too wide, full
  // queue, and a distance exactly at the cutoff.
  task automatic test_merge_cases();
    sample_t c, s;
    write_reg(CFG_BYPASS, 32'd0);
    write_reg(CFG_BG_COUNT, 32'd0);
    write_reg(CFG_BG_DOSE, 32'd0);
    write_reg(CFG_CUTOFF, 32'd2500);
    c = random_sample();
    c.pos[0] = 24'd0; c.pos[1] = 24'd0; c.pos[2] = 24'd0;
    send_sample(c);                                   // empty queue
    s = c; s.pos[0] = 24'd50; send_sample(s);         // exactly at cutoff, queued
    s = c; s.pos[0] = 24'd100; send_sample(s);        // spread 100^2 > cutoff
    drain();
    send_sample(c);
    s = c; s.pos[1] = 24'h7FFFFF; send_sample(s);     // moved away
    drain();
    for (int i = 0; i < QUEUE_DEPTH; i++) send_sample(c);  // full queue flush
    drain();
    // Largest positive and negative extremes: biggest possible distance.
    write_reg(CFG_CUTOFF, 32'hFFFFFFFF);
    s = c; for (int k = 0; k < 3; k++) s.pos[k] = 24'h800000; send_sample(s);
    s = c; for (int k = 0; k < 3; k++) s.pos[k] = 24'h7FFFFF; send_sample(s);
    drain();
  endtask

  // Random walks: clusters of nearby samples with jumps and noise, across
  // several cutoffs, backgrounds and both modes.
  task automatic test_random_walks();
    sample_t c;
    int      spread;
    logic [31:0] cutoffs [4] = '{32'd0, 32'd2500, 32'd40000, 32'hFFFFFFFF};
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_BYPASS, (phase == 3) ? 32'd1 : 32'd0);
      write_reg(CFG_CUTOFF, cutoffs[phase % 4]);
      write_reg(CFG_BG_COUNT, $urandom_range(0, 3) == 0 ? 32'hFFFFFF : $urandom_range(0, 1 << 23));
      write_reg(CFG_BG_DOSE, $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 1 << 23));
      stall_enable = (phase != 2);
      c = random_sample();
      spread = (phase % 4 == 2) ? 120 : 30;
      for (int i = 0; i < 34; i++) begin
        if ($urandom_range(0, 9) == 0) c = random_sample();
        c = near_point(c, spread);
        send_sample(c);
      end
      drain();  // the sender pauses until all expected words have come
    end
  endtask

  initial begin
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    cfg_we = 1'b0; cfg_addr = CFG_BYPASS; cfg_data = '0;
    mismatches = 0; words_checked = 0; mean_words = 0; samples_sent = 0;
    cycle_count = 0; burst_left = 0; stall_enable = 1'b1;
    sh_bypass = 1'b0; sh_bg_count = '0; sh_bg_dose = '0; sh_cutoff = CUTOFF_RESET;
    merge_fill = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_bypass_extremes();
    test_merge_cases();
    test_random_walks();
    $display("Sent %0d samples, checked %0d result words (%0d means).",
             samples_sent, words_checked, mean_words);
    $display("Covered bypass, background clamping, moves, wide spreads and full queues.");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

### sim.f
hdl/dspm_pkg.sv
hdl/dspm_datapath.sv
hdl/dspm_ctrl.sv
hdl/dose_sample_position_merger_unit.sv
dv/tb_dose_sample_position_merger_unit.sv
